FILE: hdl/rf_frame_nibble_manchester_encoder_macros.svh
// Assertion macros shared by the frame encoder RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef RF_FRAME_NIBBLE_MANCHESTER_ENCODER_MACROS_SVH
`define RF_FRAME_NIBBLE_MANCHESTER_ENCODER_MACROS_SVH

`ifndef ASSERT_OFF
`define RFNM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RFNM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RFNM_ASSERT(lbl, clk, rst, prop, msg)
`define RFNM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: hdl/rfnm_pkg.sv
// Types, constants and the line-code function of the frame encoder.
// No dependencies; imported by every module of the block.
package rfnm_pkg;

   localparam int FRAME_BYTES_DEFAULT = 64;
   localparam int OUT_LIMIT = 64;
   localparam int STEP_CNT_W = $clog2(OUT_LIMIT + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam int HEADER_MAX = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_HEADER_WORD    = 3'd0,
      REG_HEADER_LEN     = 3'd1,
      REG_TRAILER_EVEN   = 3'd2,
      REG_TRAILER_ODD    = 3'd3,
      REG_POSTAMBLE_BYTE = 3'd4
   } rfnm_reg_type;

   typedef struct packed {
      logic [63:0] header_word;
      logic [3:0]  header_len;
      logic [7:0]  trailer_even;
      logic [7:0]  trailer_odd;
      logic [7:0]  postamble_byte;
   } rfnm_cfg_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       open_new;
      logic [7:0] checksum;
      logic       total_odd;
   } rfnm_entry_type;

   typedef enum logic [6:0] {
      PH_BEGIN  = 7'b0000001,
      PH_HEADER = 7'b0000010,
      PH_DATA   = 7'b0000100,
      PH_CHECK  = 7'b0001000,
      PH_PAD    = 7'b0010000,
      PH_FOOTER = 7'b0100000,
      PH_POST   = 7'b1000000
   } rfnm_phase_type;

   // Each nibble goes LSB first with a stop bit; each bit becomes the pair (b, ~b).
   function automatic logic [19:0] rfnm_line_code(logic [7:0] v);
      logic [9:0]  seq;
      logic [19:0] code;
      seq = {v[4], v[5], v[6], v[7], 1'b1, v[0], v[1], v[2], v[3], 1'b1};
      for (int i = 0; i < 10; i++) begin
         code[2*i +: 2] = {seq[i], ~seq[i]};
      end
      return code;
   endfunction

endpackage

FILE: hdl/rfnm_front.sv
// Input side of the frame encoder: accepts command bytes and tags each one.
// Depends on rfnm_pkg; feeds rfnm_queue.
module rfnm_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_final_byte,
   input  logic                    queue_full,
   output logic                    push,
   output rfnm_pkg::rfnm_entry_type push_entry
);
   import rfnm_pkg::*;

   logic [7:0] sum_ff, sum_in;
   logic       count_odd_ff, count_odd_in;
   logic       frame_open_ff, frame_open_in;
   logic [7:0] sum_next;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;
   assign sum_next  = sum_ff + req_data_byte;

   always_comb begin
      push_entry.data      = req_data_byte;
      push_entry.last      = req_final_byte;
      push_entry.open_new  = !frame_open_ff;
      push_entry.checksum  = 8'd0 - sum_next;
      push_entry.total_odd = count_odd_ff;
   end

   always_comb begin
      sum_in        = sum_ff;
      count_odd_in  = count_odd_ff;
      frame_open_in = frame_open_ff;
      if (push) begin
         if (req_final_byte) begin
            sum_in        = '0;
            count_odd_in  = 1'b0;
            frame_open_in = 1'b0;
         end else begin
            sum_in        = sum_next;
            count_odd_in  = !count_odd_ff;
            frame_open_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff        <= '0;
         count_odd_ff  <= 1'b0;
         frame_open_ff <= 1'b0;
      end else begin
         sum_ff        <= sum_in;
         count_odd_ff  <= count_odd_in;
         frame_open_ff <= frame_open_in;
      end
   end

endmodule

FILE: hdl/rfnm_queue.sv
// Short queue of tagged command bytes between the input and output sides.
// Depends on rfnm_pkg and the assertion macro header.
`include "rf_frame_nibble_manchester_encoder_macros.svh"
module rfnm_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  rfnm_pkg::rfnm_entry_type push_entry,
   output logic                    full,
   input  logic                    pop,
   output logic                    head_valid,
   output rfnm_pkg::rfnm_entry_type head_entry
);
   import rfnm_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rfnm_entry_type entries_ff [QUEUE_DEPTH];
   rfnm_entry_type entry_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];
   assign entry_in   = push_entry;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `RFNM_ASSERT(a_count_bound, clock, reset, (count_ff <= CNT_W'(QUEUE_DEPTH)), "queue count overflow")
   `RFNM_ASSERT(a_no_pop_empty, clock, reset, (pop |-> head_valid), "pop from empty queue")
   `RFNM_ASSERT(a_no_push_full, clock, reset, (full |-> !push), "push into full queue")

endmodule

FILE: hdl/rfnm_back.sv
// Output side of the frame encoder: header, line-coded bytes, checksum and tail.
// Depends on rfnm_pkg, rfnm_queue output and the assertion macro header.
`include "rf_frame_nibble_manchester_encoder_macros.svh"
module rfnm_back #(
   parameter int FRAME_BYTES = rfnm_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rfnm_pkg::rfnm_cfg_type  cfg,
   input  logic                    head_valid,
   input  rfnm_pkg::rfnm_entry_type head_entry,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_coded_byte,
   output logic                    rsp_frame_end
);
   import rfnm_pkg::*;

   rfnm_phase_type        phase_ff, phase_in, eff_phase;
   logic [2:0]            idx_ff, idx_in;
   logic [STEP_CNT_W-1:0] n_ff, n_in, n_base, n_next;
   logic [7:0]            emitted_ff, emitted_in, emitted_next;
   logic                  cv_ff, cv_in;
   logic [3:0]            carry_ff, carry_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_coded_byte_ff, rsp_coded_byte_in;
   logic                  rsp_frame_end_ff, rsp_frame_end_in;

   logic        out_free, advance;
   logic [3:0]  hdr_len;
   logic [2:0]  hdr_last_idx;
   logic [7:0]  hdr_byte;
   logic [7:0]  code_src;
   logic [19:0] code;
   logic [23:0] code_wide;
   logic [7:0]  code_byte;
   logic        code_done;
   logic        more_post;
   logic        body_beat;
   logic        frame_start;
   logic        state_clear;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign advance  = head_valid && out_free;

   assign hdr_len      = (cfg.header_len > 4'(HEADER_MAX)) ? 4'(HEADER_MAX) : cfg.header_len;
   assign hdr_last_idx = 3'(hdr_len - 4'd1);
   assign hdr_byte     = cfg.header_word[{idx_ff, 3'b000} +: 8];

   always_comb begin
      if (phase_ff == PH_BEGIN) begin
         eff_phase = (head_entry.open_new && hdr_len != '0) ? PH_HEADER : PH_DATA;
      end else begin
         eff_phase = phase_ff;
      end
   end

   assign code_src  = (eff_phase == PH_CHECK) ? head_entry.checksum : head_entry.data;
   assign code      = rfnm_line_code(code_src);
   assign code_wide = {carry_ff, code};

   always_comb begin
      if (cv_ff) begin
         case (idx_ff[1:0])
            2'd0:    code_byte = code_wide[23:16];
            2'd1:    code_byte = code_wide[15:8];
            default: code_byte = code_wide[7:0];
         endcase
         code_done = (idx_ff == 3'd2);
      end else begin
         code_byte = (idx_ff == 3'd0) ? code[19:12] : code[11:4];
         code_done = (idx_ff == 3'd1);
      end
   end

   assign n_base       = (phase_ff == PH_BEGIN) ? '0 : n_ff;
   assign n_next       = n_base + 1'b1;
   assign emitted_next = (emitted_ff == 8'hFF) ? emitted_ff : emitted_ff + 1'b1;
   assign more_post    = (emitted_next < 8'(FRAME_BYTES)) && (n_next < STEP_CNT_W'(OUT_LIMIT));

   always_comb begin
      phase_in          = phase_ff;
      idx_in            = idx_ff;
      n_in              = n_ff;
      emitted_in        = emitted_ff;
      cv_in             = cv_ff;
      carry_in          = carry_ff;
      pop               = 1'b0;
      rsp_coded_byte_in = rsp_coded_byte_ff;
      rsp_frame_end_in  = rsp_frame_end_ff;
      rsp_valid_in      = out_free ? head_valid : rsp_valid_ff;
      if (advance) begin
         n_in              = n_next;
         emitted_in        = emitted_next;
         idx_in            = idx_ff + 1'b1;
         rsp_frame_end_in  = 1'b0;
         rsp_coded_byte_in = '0;
         case (eff_phase)
            PH_HEADER: begin
               rsp_coded_byte_in = hdr_byte;
               if (idx_ff == hdr_last_idx) begin
                  phase_in = PH_DATA;
                  idx_in   = '0;
               end else begin
                  phase_in = PH_HEADER;
               end
            end
            PH_DATA, PH_CHECK: begin
               rsp_coded_byte_in = code_byte;
               phase_in          = eff_phase;
               if (code_done) begin
                  idx_in   = '0;
                  cv_in    = !cv_ff;
                  carry_in = cv_ff ? 4'd0 : code[3:0];
                  if (eff_phase == PH_CHECK) begin
                     phase_in = cv_ff ? PH_FOOTER : PH_PAD;
                  end else if (head_entry.last) begin
                     phase_in = PH_CHECK;
                  end else begin
                     phase_in = PH_BEGIN;
                     pop      = 1'b1;
                  end
               end
            end
            PH_PAD: begin
               rsp_coded_byte_in = {carry_ff, 4'hA};
               cv_in             = 1'b0;
               carry_in          = '0;
               idx_in            = '0;
               phase_in          = PH_FOOTER;
            end
            PH_FOOTER, PH_POST: begin
               if (eff_phase == PH_FOOTER) begin
                  rsp_coded_byte_in = head_entry.total_odd ? cfg.trailer_odd : cfg.trailer_even;
               end else begin
                  rsp_coded_byte_in = cfg.postamble_byte;
               end
               idx_in = '0;
               if (more_post) begin
                  phase_in = PH_POST;
               end else begin
                  rsp_frame_end_in = 1'b1;
                  pop              = 1'b1;
                  phase_in         = PH_BEGIN;
                  emitted_in       = '0;
                  cv_in            = 1'b0;
                  carry_in         = '0;
               end
            end
            default: begin
               phase_in = PH_BEGIN;
               idx_in   = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_BEGIN;
         idx_ff       <= '0;
         n_ff         <= '0;
         emitted_ff   <= '0;
         cv_ff        <= 1'b0;
         carry_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         n_ff         <= n_in;
         emitted_ff   <= emitted_in;
         cv_ff        <= cv_in;
         carry_ff     <= carry_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_coded_byte_ff <= rsp_coded_byte_in;
      rsp_frame_end_ff  <= rsp_frame_end_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_coded_byte = rsp_coded_byte_ff;
   assign rsp_frame_end  = rsp_frame_end_ff;

   assign body_beat   = advance && (eff_phase == PH_HEADER || eff_phase == PH_DATA);
   assign frame_start = head_valid && phase_ff == PH_BEGIN && head_entry.open_new;
   assign state_clear = !cv_ff && emitted_ff == 8'd0;

   `RFNM_ASSERT(a_no_early_end, clock, reset, (body_beat |=> !rsp_frame_end_ff), "early frame end")
   `RFNM_ASSERT(a_step_limit, clock, reset, (n_ff <= STEP_CNT_W'(OUT_LIMIT)), "item byte limit")
   `RFNM_ASSERT(a_clean_start, clock, reset, (frame_start |-> state_clear), "stale frame state")

endmodule

FILE: hdl/rf_frame_nibble_manchester_encoder.sv
// Coded bytes leave one per cycle while the queue holds an item and the output is free.
// The first byte of an item passes the queue, then the single-byte result register. A
// data or checksum byte yields two or three coded bytes; header, pad, footer and
// postamble bytes yield one each. Input bytes are taken each cycle while the two-entry
// queue has room. Synchronous active-high reset resets frame state, zeroes configuration.
module rf_frame_nibble_manchester_encoder #(
   parameter int FRAME_BYTES = rfnm_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_data_byte,
   input  logic                             req_final_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_coded_byte,
   output logic                             rsp_frame_end,
   input  logic                             csr_we,
   input  logic [rfnm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rfnm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rfnm_pkg::*;

   rfnm_cfg_type   cfg_ff, cfg_in;
   rfnm_entry_type push_entry, head_entry;
   logic           push, pop, queue_full, head_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_HEADER_WORD:    cfg_in.header_word    = csr_wdata;
            REG_HEADER_LEN:     cfg_in.header_len     = csr_wdata[3:0];
            REG_TRAILER_EVEN:   cfg_in.trailer_even   = csr_wdata[7:0];
            REG_TRAILER_ODD:    cfg_in.trailer_odd    = csr_wdata[7:0];
            REG_POSTAMBLE_BYTE: cfg_in.postamble_byte = csr_wdata[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rfnm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .queue_full     (queue_full),
      .push           (push),
      .push_entry     (push_entry)
   );

   rfnm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   rfnm_back #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .head_valid     (head_valid),
      .head_entry     (head_entry),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_coded_byte (rsp_coded_byte),
      .rsp_frame_end  (rsp_frame_end)
   );

endmodule

FILE: tb/sv/rf_frame_nibble_manchester_encoder_test.sv
// Self-checking testbench for the nibble-framed Manchester frame encoder.
// It sends directed and random command frames and compares each coded byte with a predictor.
// Depends on rfnm_pkg and the rf_frame_nibble_manchester_encoder RTL.
module rf_frame_nibble_manchester_encoder_test;
   timeunit 1ns;
   timeprecision 1ps;
   import rfnm_pkg::*;

   localparam int FRAME_LEN = FRAME_BYTES_DEFAULT;
   localparam int RANDOM_ITEMS = 260;
   localparam int LONG_FRAME = 110;
   localparam int DRAIN_CYCLES = 4;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_LIMIT = 40;

   typedef enum logic { ROW_CSR, ROW_BYTE } row_kind_type;
   typedef enum logic [1:0] { RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT } rx_mode_type;

   typedef struct packed {
      row_kind_type kind;
      rfnm_reg_type sel;
      logic [63:0]  value;
      logic [7:0]   data;
      logic         final_flag;
      logic [1:0]   n_typed;
      logic [23:0]  typed;
   } stim_row_type;

   typedef struct packed {
      logic [7:0] coded;
      logic       frame_end;
   } line_byte_type;

   // Typed rows list the bytes that a transfer must produce, first byte in the top bits.
   localparam stim_row_type DIRECTED [33] = '{
      '{ROW_BYTE, REG_HEADER_WORD,    64'h0, 8'h00, 1'b0, 2'd2, 24'h559500},
      '{ROW_BYTE, REG_HEADER_WORD,    64'h0, 8'hFF, 1'b0, 2'd3, 24'h6AAAAA},
      '{ROW_BYTE, REG_HEADER_WORD,    64'h0, 8'h5A, 1'b1, 2'd0, 24'h0},
      '{ROW_BYTE, REG_HEADER_WORD,    64'h0, 8'hFF, 1'b0, 2'd2, 24'hAAAA00},
      '{ROW_BYTE, REG_HEADER_WORD,    64'h0, 8'h00, 1'b1, 2'd0, 24'h0},
      '{ROW_CSR,  REG_HEADER_WORD,    64'h8877665544332211, 8'h00, 1'b0, 2'd0, 24'h0},
      '{ROW_CSR,  REG_HEADER_LEN,     64'd8, 8'h00, 1'b0, 2'd0, 24'h0},
      '{ROW_CSR,  REG_TRAILER_EVEN,   64'hE5, 8'h00, 1'b0, 2'd0, 24'h0},
      '{ROW_CSR,  REG_TRAILER_ODD,    64'h0D, 8'h00, 1'b0, 2'd0, 24'h0},
      '{ROW_CSR,  REG_POSTAMBLE_BYTE, 64'hC3, 8'h00, 1'b0, 2'd0, 24'h0},
      '{ROW_BYTE, REG_HEADER_WORD,    64'h0, 8'h12, 1'b0, 2'd0, 24'h0},
      '{ROW_BYTE, REG_HEADER_WORD,    64'h0, 8'h34, 1'b1, 2'd0, 24'h0},
      '{ROW_BYTE, REG_HEADER_WORD,    64'h0, 8'h80, 1'b1, 2'd0, 24'h0},
      '{ROW_CSR,  REG_HEADER_LEN,     64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 2'd0, 24'h0},
      '{ROW_BYTE, REG_HEADER_WORD,    64'h0, 8'h01, 1'b1, 2'd0, 24'h0},
      '{ROW_CSR,  REG_HEADER_LEN,     64'd0, 8'h00, 1'b0, 2'd0, 24'h0},
      '{ROW_CSR,  REG_HEADER_WORD,    64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 2'd0, 24'h0},
      '{ROW_CSR,  REG_TRAILER_EVEN,   64'h00, 8'h00, 1'b0, 2'd0, 24'h0},
      '{ROW_CSR,  REG_TRAILER_ODD,    64'hFF, 8'h00, 1'b0, 2'd0, 24'h0},
      '{ROW_CSR,  REG_POSTAMBLE_BYTE, 64'hFF, 8'h00, 1'b0, 2'd0, 24'h0},
      '{ROW_BYTE, REG_HEADER_WORD,    64'h0, 8'hFF, 1'b0, 2'd0, 24'h0},
      '{ROW_BYTE, REG_HEADER_WORD,    64'h0, 8'hFF, 1'b0, 2'd0, 24'h0},
      '{ROW_BYTE, REG_HEADER_WORD,    64'h0, 8'h01, 1'b1, 2'd0, 24'h0},
      '{ROW_BYTE, REG_HEADER_WORD,    64'h0, 8'h00, 1'b1, 2'd0, 24'h0},
      '{ROW_CSR,  REG_HEADER_WORD,    64'h0, 8'h00, 1'b0, 2'd0, 24'h0},
      '{ROW_CSR,  REG_HEADER_LEN,     64'd3, 8'h00, 1'b0, 2'd0, 24'h0},
      '{ROW_BYTE, REG_HEADER_WORD,    64'h0, 8'h0F, 1'b0, 2'd0, 24'h0},
      '{ROW_BYTE, REG_HEADER_WORD,    64'h0, 8'hF0, 1'b1, 2'd0, 24'h0},
      '{ROW_BYTE, REG_HEADER_WORD,    64'h0, 8'h33, 1'b0, 2'd0, 24'h0},
      '{ROW_CSR,  REG_TRAILER_EVEN,   64'h5A, 8'h00, 1'b0, 2'd0, 24'h0},
      '{ROW_CSR,  REG_HEADER_LEN,     64'd1, 8'h00, 1'b0, 2'd0, 24'h0},
      '{ROW_BYTE, REG_HEADER_WORD,    64'h0, 8'h44, 1'b0, 2'd0, 24'h0},
      '{ROW_BYTE, REG_HEADER_WORD,    64'h0, 8'h55, 1'b1, 2'd0, 24'h0}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_data_byte = 8'h00;
   logic                   req_final_byte = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [7:0]             rsp_coded_byte;
   logic                   rsp_frame_end;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = REG_HEADER_WORD;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   rfnm_cfg_type shadow_cfg = '0;
   logic [7:0]   byte_sum = 8'h00;
   logic [3:0]   tail_bits = 4'h0;
   logic         tail_held = 1'b0;
   logic         parity_odd = 1'b0;
   int           sent_in_frame = 0;
   logic         frame_open_q = 1'b0;

   line_byte_type step_bytes[$];
   line_byte_type coded_bytes_due[$];
   int            mismatches = 0;
   int            cycle_count = 0;
   int            burst_left = 0;
   rx_mode_type   rx_mode = RX_OPEN;
   int            rx_left = 0;
   int            rx_tick = 0;

   rf_frame_nibble_manchester_encoder i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_coded_byte (rsp_coded_byte),
      .rsp_frame_end  (rsp_frame_end),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(input string what);
      if (mismatches < PRINT_LIMIT) begin
         $display("mismatch at %0t: %s", $time, what);
      end
      mismatches++;
   endtask

   function automatic void put_line_byte(input logic [7:0] b);
      line_byte_type nb;
      if (step_bytes.size() >= OUT_LIMIT) return;
      nb.coded = b;
      nb.frame_end = 1'b0;
      step_bytes = {step_bytes, nb};
      if (sent_in_frame < 255) sent_in_frame++;
   endfunction

   function automatic void code_into_line(input logic [7:0] v);
      logic [19:0] pairs;
      logic [23:0] joined;
      logic [3:0]  nib;
      logic        b;
      pairs = '0;
      for (int j = 0; j < 2; j++) begin
         nib = (j == 0) ? v[7:4] : v[3:0];
         for (int k = 0; k < 5; k++) begin
            b = (k < 4) ? nib[k] : 1'b1;
            pairs = {pairs[17:0], b, ~b};
         end
      end
      if (tail_held) begin
         joined = {tail_bits, pairs};
         put_line_byte(joined[23:16]);
         put_line_byte(joined[15:8]);
         put_line_byte(joined[7:0]);
         tail_held = 1'b0;
         tail_bits = 4'h0;
      end else begin
         put_line_byte(pairs[19:12]);
         put_line_byte(pairs[11:4]);
         tail_bits = pairs[3:0];
         tail_held = 1'b1;
      end
   endfunction

   function automatic void predict_line_bytes(input logic [7:0] d, input logic f);
      int   hlen;
      logic total_odd;
      step_bytes.delete();
      if (!frame_open_q) begin
         hlen = (shadow_cfg.header_len > 4'd8) ? 8 : int'(shadow_cfg.header_len);
         for (int i = 0; i < hlen; i++) begin
            put_line_byte(shadow_cfg.header_word[8*i +: 8]);
         end
         frame_open_q = 1'b1;
      end
      code_into_line(d);
      byte_sum += d;
      parity_odd = ~parity_odd;
      if (f) begin
         code_into_line(8'h00 - byte_sum);
         total_odd = ~parity_odd;
         if (tail_held) begin
            put_line_byte({tail_bits, 4'hA});
         end
         put_line_byte(total_odd ? shadow_cfg.trailer_odd : shadow_cfg.trailer_even);
         while (sent_in_frame < FRAME_LEN && step_bytes.size() < OUT_LIMIT) begin
            put_line_byte(shadow_cfg.postamble_byte);
         end
         step_bytes[step_bytes.size() - 1].frame_end = 1'b1;
         byte_sum = 8'h00;
         tail_bits = 4'h0;
         tail_held = 1'b0;
         parity_odd = 1'b0;
         sent_in_frame = 0;
         frame_open_q = 1'b0;
      end
   endfunction

   task automatic push_byte(input logic [7:0] d, input logic f, input logic [1:0] n_typed,
                            input logic [23:0] typed);
      int            gap;
      line_byte_type want;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data_byte <= d;
      req_final_byte <= f;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      predict_line_bytes(d, f);
      if (n_typed == 2'd0) begin
         coded_bytes_due = {coded_bytes_due, step_bytes};
      end else begin
         for (int t = 0; t < n_typed; t++) begin
            want.coded = typed[23 - 8*t -: 8];
            want.frame_end = 1'b0;
            coded_bytes_due = {coded_bytes_due, want};
         end
      end
      @(negedge clock);
   endtask

   task automatic settle_outputs();
      req_valid <= 1'b0;
      while (coded_bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input rfnm_reg_type sel, input logic [63:0] val);
      csr_we <= 1'b1;
      csr_index <= sel;
      csr_wdata <= val;
      case (sel)
         REG_HEADER_WORD:    shadow_cfg.header_word = val;
         REG_HEADER_LEN:     shadow_cfg.header_len = val[3:0];
         REG_TRAILER_EVEN:   shadow_cfg.trailer_even = val[7:0];
         REG_TRAILER_ODD:    shadow_cfg.trailer_odd = val[7:0];
         REG_POSTAMBLE_BYTE: shadow_cfg.postamble_byte = val[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(16, 120);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
         RX_OPEN:   rsp_ready <= 1'b1;
         RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:   rsp_ready <= ((rx_tick % 5) < 3);
      endcase
   end

   always @(posedge clock) begin : check_transfer
      line_byte_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (coded_bytes_due.size() == 0) begin
            report_mismatch($sformatf("unexpected coded byte %02h", rsp_coded_byte));
         end else begin
            want = coded_bytes_due.pop_front();
            if (rsp_coded_byte !== want.coded) begin
               report_mismatch($sformatf("coded_byte %02h, expected %02h",
                                         rsp_coded_byte, want.coded));
            end
            if (rsp_frame_end !== want.frame_end) begin
               report_mismatch($sformatf("frame_end %b, expected %b",
                                         rsp_frame_end, want.frame_end));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin : stimulus
      int           items_sent;
      int           frame_left;
      int           phase_left;
      int           pick;
      bit           long_done;
      bit           first_phase;
      logic [63:0]  wval;
      rfnm_reg_type sel;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED[r]) begin
         if (DIRECTED[r].kind == ROW_CSR) begin
            settle_outputs();
            write_reg(DIRECTED[r].sel, DIRECTED[r].value);
         end else begin
            push_byte(DIRECTED[r].data, DIRECTED[r].final_flag, DIRECTED[r].n_typed,
                      DIRECTED[r].typed);
         end
      end

      // Phases may end inside a frame, so register writes also land while a frame is open.
      items_sent = 0;
      frame_left = 0;
      long_done = 1'b0;
      first_phase = 1'b1;
      while (items_sent < RANDOM_ITEMS || frame_left != 0) begin
         settle_outputs();
         for (int k = REG_HEADER_WORD; k <= REG_POSTAMBLE_BYTE; k++) begin
            sel = rfnm_reg_type'(k);
            if (first_phase || $urandom_range(0, 1) == 1) begin
               wval = {$urandom(), $urandom()};
               pick = $urandom_range(0, 5);
               case (sel)
                  REG_HEADER_WORD: begin
                     if (pick == 0) wval = '0;
                     else if (pick == 1) wval = '1;
                  end
                  REG_HEADER_LEN: begin
                     wval[3:0] = (pick == 0) ? 4'd0 :
                                 (pick == 1) ? 4'd8 :
                                 (pick == 2) ? 4'($urandom_range(9, 15)) :
                                 4'($urandom_range(1, 7));
                  end
                  default: begin
                     if (pick == 0) wval[7:0] = 8'h00;
                     else if (pick == 1) wval[7:0] = 8'hFF;
                  end
               endcase
               write_reg(sel, wval);
            end
         end
         first_phase = 1'b0;
         phase_left = $urandom_range(4, 40);
         while (phase_left > 0 && (items_sent < RANDOM_ITEMS || frame_left != 0)) begin
            if (frame_left == 0) begin
               pick = $urandom_range(0, 9);
               if (!long_done && items_sent >= 40) begin
                  frame_left = LONG_FRAME;
                  long_done = 1'b1;
               end else if (pick < 6) begin
                  frame_left = $urandom_range(1, 6);
               end else if (pick < 8) begin
                  frame_left = $urandom_range(7, 16);
               end else if (pick == 8) begin
                  frame_left = $urandom_range(20, 35);
               end else begin
                  frame_left = 1;
               end
            end
            push_byte(8'($urandom_range(0, 255)), frame_left == 1, 2'd0, 24'h0);
            frame_left--;
            items_sent++;
            phase_left--;
         end
      end

      settle_outputs();
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
